[rtl/mie_pkg.sv]
// mie_pkg: shared types for the extended euclidean modular inverse block
// sequencer state encoding used by the top level
// no dependencies
package mie_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_SUB,
		ST_SWAP,
		ST_DONE
	} state_t;

endpackage

[rtl/modular_inverse_ext_euclid.sv]
// modular_inverse_ext_euclid: modular inverse by the extended euclidean algorithm
// one shared shift/subtract unit under a small sequencer
// depends on mie_pkg
//
// Usage: drive value and modulus and pulse start while busy is low; the item is
// taken at that edge. busy then stays high until the result has been shown.
// The result (inverse_coefficient, common_divisor, invertible) is on the ports
// for exactly one cycle, marked by done; the receiver cannot stall it.
// Each quotient step of euclid is a restoring long division: the divisor and
// the running coefficient are shifted up one bit at a time until aligned, then
// one subtract-and-compare a cycle walks back down, and a swap state exchanges
// the operands. Every step runs on the single subtractor pair. A zero modulus
// skips the division steps and goes straight to done. A new item can be taken
// the cycle after done.
// The coefficient is carried signed in WIDTH+2 bits and is exact.
// Reset returns the sequencer to idle and drops busy and done.
module modular_inverse_ext_euclid #(
	parameter int WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [WIDTH-1:0]        value,
	input  logic [WIDTH-1:0]        modulus,
	output logic                    done,
	output logic signed [WIDTH:0]   inverse_coefficient,
	output logic [WIDTH-1:0]        common_divisor,
	output logic                    invertible
);

	localparam int KW = $clog2(WIDTH);

	mie_pkg::state_t state_q, state_d;

	logic [WIDTH-1:0]          a_q, b_q, bs_q;
	logic signed [WIDTH+1:0]   cp_q, cc_q, cs_q;
	logic [KW-1:0]             k_q;

	// shared unit: divisor alignment test and restoring subtract
	logic [WIDTH:0]            bs_dbl;
	logic                      can_shift;
	logic                      can_sub;
	logic [WIDTH-1:0]          a_diff;
	logic signed [WIDTH+1:0]   cp_diff;

	assign bs_dbl    = {bs_q, 1'b0};
	assign can_shift = (bs_dbl <= {1'b0, a_q});
	assign can_sub   = (bs_q <= a_q);
	assign a_diff    = a_q - bs_q;
	assign cp_diff   = cp_q - cs_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mie_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (modulus == '0) ? mie_pkg::ST_DONE : mie_pkg::ST_ALIGN;
				end
			end
			mie_pkg::ST_ALIGN: begin
				if (!can_shift) begin
					state_d = mie_pkg::ST_SUB;
				end
			end
			mie_pkg::ST_SUB: begin
				if (k_q == '0) begin
					state_d = mie_pkg::ST_SWAP;
				end
			end
			mie_pkg::ST_SWAP: begin
				state_d = (a_q == '0) ? mie_pkg::ST_DONE : mie_pkg::ST_ALIGN;
			end
			mie_pkg::ST_DONE: begin
				state_d = mie_pkg::ST_IDLE;
			end
			default: begin
				state_d = mie_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mie_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			mie_pkg::ST_IDLE: begin
				a_q  <= value;
				b_q  <= modulus;
				bs_q <= modulus;
				cp_q <= (WIDTH+2)'(1);
				cc_q <= '0;
				cs_q <= '0;
				k_q  <= '0;
			end
			mie_pkg::ST_ALIGN: begin
				if (can_shift) begin
					bs_q <= bs_dbl[WIDTH-1:0];
					cs_q <= cs_q <<< 1;
					k_q  <= k_q + KW'(1);
				end
			end
			mie_pkg::ST_SUB: begin
				if (can_sub) begin
					a_q  <= a_diff;
					cp_q <= cp_diff;
				end
				if (k_q != '0) begin
					bs_q <= bs_q >> 1;
					cs_q <= cs_q >>> 1;
					k_q  <= k_q - KW'(1);
				end
			end
			mie_pkg::ST_SWAP: begin
				// remainder becomes the new divisor, old divisor the new dividend
				a_q  <= b_q;
				b_q  <= a_q;
				bs_q <= a_q;
				cp_q <= cc_q;
				cc_q <= cp_q;
				cs_q <= cp_q;
				k_q  <= '0;
			end
			mie_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		busy                = (state_q != mie_pkg::ST_IDLE);
		done                = (state_q == mie_pkg::ST_DONE);
		common_divisor      = a_q;
		invertible          = done && (a_q == WIDTH'(1));
		inverse_coefficient = invertible ? cp_q[WIDTH:0] : '0;
	end

endmodule

[rtl/mie_checker.sv]
// mie_checker: port-level checks for modular_inverse_ext_euclid
// bound to the top level below; depends on no package
module mie_checker #(
	parameter int WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic signed [WIDTH:0] inverse_coefficient,
	input logic [WIDTH-1:0]      common_divisor,
	input logic                  invertible
);

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// the result strobe lasts exactly one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an invertible result carries a divisor of one
	a_inv_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		done && invertible |-> common_divisor == WIDTH'(1))
		else $error("invertible flag with divisor other than one");

	// a non-invertible result carries a zero coefficient
	a_noinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !invertible |-> inverse_coefficient == '0)
		else $error("nonzero coefficient on a non-invertible result");

endmodule

bind modular_inverse_ext_euclid mie_checker #(.WIDTH(WIDTH)) u_mie_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.start               (start),
	.busy                (busy),
	.done                (done),
	.inverse_coefficient (inverse_coefficient),
	.common_divisor      (common_divisor),
	.invertible          (invertible)
);

[sim/tb_modular_inverse_ext_euclid.sv]
// tb_modular_inverse_ext_euclid: self-checking bench for the euclidean modular inverse
// predicts gcd, invertible flag and signed coefficient per item and compares each result
// depends on rtl/modular_inverse_ext_euclid.sv
module tb_modular_inverse_ext_euclid;

	localparam int W            = 32;
	localparam int STALL_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 300;
	localparam int REPORT_FIRST = 10;

	typedef struct {
		logic [W-1:0]  value;
		logic [W-1:0]  modulus;
		logic signed [W:0] coefficient;
		logic [W-1:0]  divisor;
		logic          invertible;
	} inverse_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [W-1:0]        value;
	logic [W-1:0]        modulus;
	logic                done;
	logic signed [W:0]   inverse_coefficient;
	logic [W-1:0]        common_divisor;
	logic                invertible;

	inverse_t pending_inverses[$];
	bit       idle_on;
	int       items_sent;
	int       results_seen;
	int       coprime_seen;
	int       mismatches;
	int       quiet_cycles;

	modular_inverse_ext_euclid #(
		.WIDTH(W)
	) i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.value               (value),
		.modulus             (modulus),
		.done                (done),
		.inverse_coefficient (inverse_coefficient),
		.common_divisor      (common_divisor),
		.invertible          (invertible)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// extended euclid: gcd and bezout coefficient of v, kept in wrapping 64-bit arithmetic
	function automatic inverse_t euclid_inverse(logic [W-1:0] v, logic [W-1:0] m);
		logic [63:0] a, b, q, r, c_prev, c_cur, c_next;
		inverse_t res;
		a = v;
		b = m;
		c_prev = 64'd1;
		c_cur = 64'd0;
		while (b != 64'd0) begin
			q = a / b;
			r = a - q * b;
			c_next = c_prev - q * c_cur;
			a = b;
			b = r;
			c_prev = c_cur;
			c_cur = c_next;
		end
		res.value = v;
		res.modulus = m;
		res.divisor = a[W-1:0];
		res.invertible = (a == 64'd1);
		res.coefficient = res.invertible ? $signed(c_prev[W:0]) : '0;
		return res;
	endfunction

	// random operand of random bit length
	function automatic logic [W-1:0] shaped_operand();
		return $urandom >> $urandom_range(W - 1);
	endfunction

	// fibonacci numbers F(k) and F(k-1), the longest quotient chains
	task automatic fib_pair(input int k, output logic [W-1:0] hi, output logic [W-1:0] lo);
		logic [W-1:0] t;
		hi = 1;
		lo = 0;
		for (int i = 1; i < k; i++) begin
			t = hi + lo;
			lo = hi;
			hi = t;
		end
	endtask

	// acceptance, result check and stall watchdog
	always @(posedge clk) begin
		inverse_t want;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (invertible)
					coprime_seen++;
				if (pending_inverses.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_FIRST)
						$display("unexpected result: coef %0d gcd %h inv %b",
							inverse_coefficient, common_divisor, invertible);
				end else begin
					want = pending_inverses.pop_front();
					if (inverse_coefficient !== want.coefficient ||
						common_divisor !== want.divisor || invertible !== want.invertible) begin
						mismatches++;
						if (mismatches <= REPORT_FIRST)
							$display("mismatch v=%h m=%h: coef exp %0d got %0d, gcd exp %h got %h, inv exp %b got %b",
								want.value, want.modulus, want.coefficient, inverse_coefficient,
								want.divisor, common_divisor, want.invertible, invertible);
					end
				end
			end
			if (start && !busy) begin
				pending_inverses.push_back(euclid_inverse(value, modulus));
				items_sent++;
			end
			// nothing moving for too long means the block has hung
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no item or result for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// offer one item, idling at random when idle_on is set, until the block takes it
	task automatic send_item(input logic [W-1:0] v, input logic [W-1:0] m);
		bit taken;
		taken = 1'b0;
		do begin
			if (idle_on && $urandom_range(99) < 24) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				value <= v;
				modulus <= m;
			end
			@(posedge clk);
			taken = start && !busy;
		end while (!taken);
	endtask

	// let every outstanding item finish
	task automatic wait_drained(input int tail);
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_inverses.size() != 0 || busy);
		repeat (tail) @(posedge clk);
	endtask

	// extremes of both fields and the named corner cases
	task automatic test_extremes();
		logic [W-1:0] hi, lo;
		send_item('0, '0);
		send_item(1, '0);
		send_item(32'd5, '0);
		send_item('1, '0);
		send_item('0, 1);
		send_item('0, 32'd7);
		send_item('0, '1);
		send_item(1, 1);
		send_item('1, '1);
		send_item('1, 1);
		send_item(1, '1);
		send_item('1, '1 - 1);
		send_item('1 - 1, '1);
		send_item(32'd3, 32'd7);
		send_item(32'd7, 32'd3);
		send_item(32'd10, 32'd4);
		send_item(32'd6, 32'd9);
		send_item(32'd17, 32'd3120);
		send_item(32'h8000_0000, 32'h8000_0000);
		send_item(32'h8000_0000, 32'h7fff_ffff);
		send_item(32'h5555_5555, 32'haaaa_aaaa);
		fib_pair(47, hi, lo);
		send_item(hi, lo);
		send_item(lo, hi);
		wait_drained(4);
	endtask

	// mixed random items: full range, shaped widths, shared factors, near pairs
	task automatic test_random_mix(input int count);
		logic [W-1:0] v, m, g, hi, lo;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					v = $urandom;
					m = $urandom;
				end
				3: begin
					v = shaped_operand();
					m = shaped_operand();
				end
				4: begin
					m = shaped_operand();
					v = $urandom | m;
				end
				5: begin
					g = $urandom_range(2, 65535);
					v = $urandom_range('1 / g) * g;
					m = $urandom_range('1 / g) * g;
				end
				6: begin
					fib_pair($urandom_range(2, 47), hi, lo);
					if ($urandom_range(1)) begin
						v = hi;
						m = lo;
					end else begin
						v = lo;
						m = hi;
					end
				end
				7: begin
					v = $urandom_range(255);
					m = $urandom_range(255);
				end
				8: begin
					case ($urandom_range(3))
						0: begin v = $urandom; m = '0; end
						1: begin v = '0; m = $urandom; end
						2: begin v = $urandom; m = 1; end
						default: begin
							v = 32'd1 << $urandom_range(W - 1);
							m = v + ($urandom_range(1) ? 1 : -1);
						end
					endcase
				end
				default: begin
					v = $urandom;
					m = v + $urandom_range(16) - 8;
				end
			endcase
			send_item(v, m);
		end
		wait_drained(4);
	endtask

	// back-to-back items with no idling on the sending side
	task automatic test_back_to_back(input int count);
		idle_on = 1'b0;
		for (int n = 0; n < count; n++)
			send_item($urandom, shaped_operand());
		wait_drained(4);
		idle_on = 1'b1;
	endtask

	// long quotient chains: fibonacci neighbours, plain or perturbed
	task automatic test_long_chains(input int count);
		logic [W-1:0] hi, lo;
		int k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(30, 47);
			fib_pair(k, hi, lo);
			case ($urandom_range(3))
				0: send_item(hi, lo);
				1: send_item(lo, hi);
				2: send_item(hi + $urandom_range(3), lo);
				default: send_item(hi, lo + $urandom_range(3));
			endcase
		end
		wait_drained(4);
	endtask

	// test sequence
	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		value <= '0;
		modulus <= '0;
		idle_on = 1'b1;
		items_sent = 0;
		results_seen = 0;
		coprime_seen = 0;
		mismatches = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_random_mix(1300);
		test_back_to_back(300);
		test_long_chains(300);
		wait_drained(TAIL_CYCLES);

		$display("covered %0d items, %0d results, %0d of them invertible",
			items_sent, results_seen, coprime_seen);
		$display("zero operands, shared factors, fibonacci chains and back-to-back starts exercised");
		if (mismatches == 0 && pending_inverses.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_inverses.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
